// ----- sv/ffea_pkg.sv -----
`default_nettype none

package ffea_pkg;

    localparam int FIELD_BITS = 24;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_NO_SPACE   = 2'd2;

    typedef struct packed {
        logic                  opcode;
        logic [FIELD_BITS-1:0] start_block;
        logic [FIELD_BITS-1:0] run_length;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] granted_block;
        logic [FIELD_BITS-1:0] end_block;
    } rsp_t;

    // Per-slot compare results for the entry on the RAM read port
    typedef struct packed {
        logic fit;
        logic exact;
        logic prior;
        logic after;
        logic empty;
    } match_t;

endpackage

`default_nettype wire

// ----- sv/ffea_ram.sv -----
`default_nettype none

module ffea_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/ffea_match.sv -----
`default_nettype none

module ffea_match #(
    parameter int BLOCK_BITS = 24
) (
    input  wire logic                  used,
    input  wire logic [BLOCK_BITS-1:0] first,
    input  wire logic [BLOCK_BITS-1:0] size,
    input  wire logic [BLOCK_BITS-1:0] start,
    input  wire logic [BLOCK_BITS-1:0] stop,
    input  wire logic [BLOCK_BITS-1:0] len,
    output ffea_pkg::match_t           m
);

    import ffea_pkg::*;

    logic [BLOCK_BITS-1:0] last;

    assign last = first + size;

    always_comb
    begin
        m.fit    = used && (size >= len);
        m.exact  = (size == len);
        m.prior  = used && (last == start);
        // an extent ending at the run's start is never taken as the one after
        m.after  = used && (last != start) && (first == stop);
        m.empty  = !used;
    end

endmodule

`default_nettype wire

// ----- sv/first_fit_extent_allocator.sv -----
`default_nettype none

// First-fit extent allocator.
// Requests arrive on req (valid/ready): opcode 0 allocates run_length blocks,
// opcode 1 frees run_length blocks starting at start_block. Each request gives
// one response transaction on rsp (valid/ready) with status, the granted block
// and the end pointer after the operation. cfg (valid/ready, always ready)
// loads the end pointer; write it only while no request is in flight.
// Free extents live in one RAM of TABLE_SLOTS words {used, first, size}.
// After reset the block clears that RAM, one slot a cycle, with req_ready
// low; the end pointer resets to 1. A zero-length request or a free that
// trims the end pointer goes straight to the response; otherwise the slot
// scan runs, one RAM read per cycle (an allocate stops at the first fit),
// followed by the update state and, for a free that merges with both
// neighbors, the unlink state. One request is processed at a time.
// The response sits in an output register; the next request is taken while it
// waits, and a stalled receiver holds the following request in its last cycle.
module first_fit_extent_allocator #(
    parameter int TABLE_SLOTS = 256,
    parameter int BLOCK_BITS  = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire ffea_pkg::req_t                req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output ffea_pkg::rsp_t                     rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ffea_pkg::FIELD_BITS-1:0] cfg_data
);

    import ffea_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int WORD_BITS = 1 + 2 * BLOCK_BITS;
    localparam logic [CNT_BITS-1:0]   SLOT_COUNT = CNT_BITS'(TABLE_SLOTS);
    localparam logic [SLOT_BITS-1:0]  LAST_SLOT  = SLOT_BITS'(TABLE_SLOTS - 1);
    localparam logic [BLOCK_BITS-1:0] END_RESET  = BLOCK_BITS'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_UNLINK,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  rd_pending_reg;
    logic [SLOT_BITS-1:0]  rd_idx_reg;

    logic                  op_reg;
    logic [BLOCK_BITS-1:0] start_reg;
    logic [BLOCK_BITS-1:0] len_reg;
    logic [BLOCK_BITS-1:0] stop_reg;
    logic [BLOCK_BITS-1:0] end_reg;

    logic                  fit_found_reg;
    logic                  fit_exact_reg;
    logic [SLOT_BITS-1:0]  fit_idx_reg;
    logic [BLOCK_BITS-1:0] fit_first_reg;
    logic [BLOCK_BITS-1:0] fit_size_reg;

    logic                  bef_found_reg;
    logic [SLOT_BITS-1:0]  bef_idx_reg;
    logic [BLOCK_BITS-1:0] bef_first_reg;
    logic [BLOCK_BITS-1:0] bef_size_reg;

    logic                  aft_found_reg;
    logic [SLOT_BITS-1:0]  aft_idx_reg;
    logic [BLOCK_BITS-1:0] aft_first_reg;
    logic [BLOCK_BITS-1:0] aft_size_reg;

    logic                  emp_found_reg;
    logic [SLOT_BITS-1:0]  emp_idx_reg;

    logic [1:0]            status_reg;
    logic [BLOCK_BITS-1:0] granted_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  rd_used;
    logic [BLOCK_BITS-1:0] rd_first;
    logic [BLOCK_BITS-1:0] rd_size;
    match_t                m;

    logic [BLOCK_BITS-1:0] in_start;
    logic [BLOCK_BITS-1:0] in_len;
    logic [BLOCK_BITS-1:0] in_stop;
    logic [BLOCK_BITS:0]   end_sum;
    logic [BLOCK_BITS-1:0] merge_size;
    logic                  rsp_free;

    assign in_start = BLOCK_BITS'(req.start_block);
    assign in_len   = BLOCK_BITS'(req.run_length);
    assign in_stop  = in_start + in_len;
    assign end_sum  = {1'b0, end_reg} + {1'b0, len_reg};

    assign merge_size = bef_size_reg + len_reg + (aft_found_reg ? aft_size_reg : '0);

    assign rd_used  = ram_rdata[WORD_BITS-1];
    assign rd_first = ram_rdata[2*BLOCK_BITS-1:BLOCK_BITS];
    assign rd_size  = ram_rdata[BLOCK_BITS-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign ram_re = (state_reg == S_SCAN) && (cnt_reg < SLOT_COUNT);

    ffea_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(cnt_reg[SLOT_BITS-1:0]),
        .rdata(ram_rdata)
    );

    ffea_match #(
        .BLOCK_BITS(BLOCK_BITS)
    ) u_match (
        .used (rd_used),
        .first(rd_first),
        .size (rd_size),
        .start(start_reg),
        .stop (stop_reg),
        .len  (len_reg),
        .m    (m)
    );

    // Write-back port: clear pass, slot update, and unlink of a merged neighbor
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[SLOT_BITS-1:0];
        ram_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_UPDATE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    ram_we    = fit_found_reg;
                    ram_waddr = fit_idx_reg;
                    if (fit_exact_reg)
                    begin
                        ram_wdata = {1'b0, fit_first_reg, fit_size_reg};
                    end
                    else
                    begin
                        ram_wdata = {1'b1, fit_first_reg + len_reg, fit_size_reg - len_reg};
                    end
                end
                else if (bef_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = bef_idx_reg;
                    ram_wdata = {1'b1, bef_first_reg, merge_size};
                end
                else if (aft_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = aft_idx_reg;
                    ram_wdata = {1'b1, aft_first_reg - len_reg, aft_size_reg + len_reg};
                end
                else if (emp_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = emp_idx_reg;
                    ram_wdata = {1'b1, start_reg, len_reg};
                end
            end
            S_UNLINK:
            begin
                ram_we    = 1'b1;
                ram_waddr = aft_idx_reg;
                ram_wdata = {1'b0, aft_first_reg, aft_size_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            rd_pending_reg <= 1'b0;
            rd_idx_reg     <= '0;
            op_reg         <= OP_ALLOC;
            start_reg      <= '0;
            len_reg        <= '0;
            stop_reg       <= '0;
            end_reg        <= END_RESET;
            fit_found_reg  <= 1'b0;
            fit_exact_reg  <= 1'b0;
            fit_idx_reg    <= '0;
            fit_first_reg  <= '0;
            fit_size_reg   <= '0;
            bef_found_reg  <= 1'b0;
            bef_idx_reg    <= '0;
            bef_first_reg  <= '0;
            bef_size_reg   <= '0;
            aft_found_reg  <= 1'b0;
            aft_idx_reg    <= '0;
            aft_first_reg  <= '0;
            aft_size_reg   <= '0;
            emp_found_reg  <= 1'b0;
            emp_idx_reg    <= '0;
            status_reg     <= ST_OK;
            granted_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[SLOT_BITS-1:0] == LAST_SLOT)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg         <= req.opcode;
                        start_reg      <= in_start;
                        len_reg        <= in_len;
                        stop_reg       <= in_stop;
                        cnt_reg        <= '0;
                        rd_pending_reg <= 1'b0;
                        fit_found_reg  <= 1'b0;
                        bef_found_reg  <= 1'b0;
                        aft_found_reg  <= 1'b0;
                        emp_found_reg  <= 1'b0;
                        status_reg     <= ST_OK;
                        granted_reg    <= '0;
                        if (in_len == '0)
                        begin
                            if (req.opcode == OP_ALLOC)
                            begin
                                granted_reg <= end_reg;
                            end
                            state_reg <= S_DONE;
                        end
                        else if ((req.opcode == OP_FREE) && (in_stop == end_reg))
                        begin
                            // freed run touches the end: pull the end pointer back
                            end_reg   <= end_reg - in_len;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg < SLOT_COUNT)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    rd_pending_reg <= ram_re;
                    rd_idx_reg     <= cnt_reg[SLOT_BITS-1:0];
                    if (rd_pending_reg)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            if (m.fit)
                            begin
                                fit_found_reg <= 1'b1;
                                fit_exact_reg <= m.exact;
                                fit_idx_reg   <= rd_idx_reg;
                                fit_first_reg <= rd_first;
                                fit_size_reg  <= rd_size;
                                state_reg     <= S_UPDATE;
                            end
                        end
                        else
                        begin
                            // later slots override earlier ones for each role
                            if (m.prior)
                            begin
                                bef_found_reg <= 1'b1;
                                bef_idx_reg   <= rd_idx_reg;
                                bef_first_reg <= rd_first;
                                bef_size_reg  <= rd_size;
                            end
                            if (m.after)
                            begin
                                aft_found_reg <= 1'b1;
                                aft_idx_reg   <= rd_idx_reg;
                                aft_first_reg <= rd_first;
                                aft_size_reg  <= rd_size;
                            end
                            if (m.empty)
                            begin
                                emp_found_reg <= 1'b1;
                                emp_idx_reg   <= rd_idx_reg;
                            end
                        end
                        if (rd_idx_reg == LAST_SLOT)
                        begin
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= S_DONE;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (fit_found_reg)
                        begin
                            granted_reg <= fit_first_reg;
                        end
                        else if (end_sum[BLOCK_BITS])
                        begin
                            status_reg <= ST_NO_SPACE;
                        end
                        else
                        begin
                            granted_reg <= end_reg;
                            end_reg     <= end_sum[BLOCK_BITS-1:0];
                        end
                    end
                    else
                    begin
                        if (!bef_found_reg && !aft_found_reg && !emp_found_reg)
                        begin
                            status_reg <= ST_TABLE_FULL;
                        end
                        if (bef_found_reg && aft_found_reg)
                        begin
                            state_reg <= S_UNLINK;
                        end
                    end
                end
                S_UNLINK:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.status        <= status_reg;
                        rsp_reg.granted_block <= FIELD_BITS'(granted_reg);
                        rsp_reg.end_block     <= FIELD_BITS'(end_reg);
                        rsp_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_valid)
            begin
                end_reg <= BLOCK_BITS'(cfg_data);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_unlink_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UNLINK |-> $past(state_reg) == S_UPDATE
                                  && bef_found_reg && aft_found_reg)
        else $error("unlink without a two-sided merge");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response raised outside the done state");

    a_no_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_NO_SPACE |-> rsp_reg.granted_block == '0)
        else $error("exhausted allocate reports a granted block");

    a_end_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && !cfg_valid |=> $stable(end_reg))
        else $error("end pointer moved during the slot scan");
`endif

endmodule

`default_nettype wire
